// File: src/gle_pkg.sv
// Shared types, constants and helpers for the GIF LZW encoder.
package gle_pkg;

  // Dictionary geometry
  localparam int TABLE_SIZE = 16384;
  localparam int IDX_W      = $clog2(TABLE_SIZE);

  // Multiplicative hash: low 32 bits of key * HASH_MUL, top bits kept
  localparam logic [31:0] HASH_MUL = 32'h9E37_79B1;
  localparam int HASH_SHIFT = 18;
  localparam int HASH_W     = 32 - HASH_SHIFT;
  localparam int RED_W      = ((IDX_W > HASH_W) ? IDX_W : HASH_W) + 1;

  // LZW code space
  localparam int CODE_W = 12;
  localparam int KEY_W  = CODE_W + 8;
  localparam logic [CODE_W-1:0] MAX_CODE  = 12'd4095;
  localparam logic [3:0]        MAX_WIDTH = 4'd12;
  localparam logic [3:0]        MIN_SIZE_LO  = 4'd2;
  localparam logic [3:0]        MIN_SIZE_HI  = 4'd8;
  localparam logic [3:0]        MIN_SIZE_RST = 4'd8;

  // Dictionary generation tag; zero marks a wiped entry
  localparam int EPOCH_W = 8;

  // Bit packer
  localparam int ACC_W = 20;
  localparam int CNT_W = 5;

  // Front-to-back queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Classified pixel as it travels from front to back
  typedef struct packed {
    logic       start;  // first pixel of a frame
    logic       last;   // final pixel of a frame
    logic [3:0] fm;     // minimum code size of this frame
    logic [7:0] pix;    // palette index, already masked to fm bits
  } item_t;

  // One code for the bit packer
  typedef struct packed {
    logic              final_code;  // end-of-information: flush afterwards
    logic [3:0]        width;
    logic [CODE_W-1:0] code;
  } pk_cmd_t;

  // One dictionary slot
  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic [KEY_W-1:0]   key;
    logic [CODE_W-1:0]  code;
  } dict_entry_t;

  // Fold the hash into table range; the hash stays below twice the table size
  function automatic logic [IDX_W-1:0] reduce_hash(input logic [HASH_W-1:0] h);
    logic [RED_W-1:0] wide;
    wide = RED_W'(h);
    if (wide >= RED_W'(TABLE_SIZE)) begin
      wide = wide - RED_W'(TABLE_SIZE);
    end
    return wide[IDX_W-1:0];
  endfunction

endpackage

// File: src/gif_lzw_encoder_unit.sv
// Top level of the GIF LZW encoder: front, queue, dictionary engine, packer.
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata[7:0] pixel_index, tlast last_pixel
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata[7:0] out_byte, tlast last_byte
//  cfg       in   cfg_valid/cfg_ready           cfg_data[3:0] min_code_size
//
// A continuing pixel whose dictionary lookup hits on the first probe passes the
// dequeue, hash multiply, read issue and compare steps in the dictionary engine;
// each further linear probe adds a read and compare on the single dictionary read
// port. A miss also emits the prefix code and waits while the packer still holds 8
// or more bits, since it drains one byte per cycle while the output is not stalled.
// A frame's first pixel also emits the clear code; a last pixel also emits its two
// closing codes. After reset, and on every 255th dictionary reset, a clearing pass
// over all TABLE_SIZE (16384) entries runs; s_axis_tready stays low during it.
// rst is synchronous and active high. Input and output stall independently: a
// two-entry queue decouples the front from the engine, and the output register
// holds a byte while m_axis_tready is low.
module gif_lzw_encoder_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] cfg_data,       // [3:0] min_code_size
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] pixel_index
  input  logic       s_axis_tlast,   // last_pixel
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast    // last_byte
);
  import gle_pkg::*;

  // Front to queue
  logic    fq_valid;
  logic    fq_ready;
  item_t   fq_item;
  // Queue to dictionary engine
  logic    qb_valid;
  logic    qb_ready;
  item_t   qb_item;
  // Engine to packer
  logic    pk_valid;
  logic    pk_ready;
  pk_cmd_t pk_cmd;
  // Hold off new pixels while the dictionary is wiped
  logic    wiping;

  // Classify pixels: frame start, last pixel, masked index, latched code size
  gle_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .wiping        (wiping),
    .q_valid       (fq_valid),
    .q_ready       (fq_ready),
    .q_item        (fq_item)
  );

  // Buffer classified pixels so the front keeps taking transactions during lookups
  gle_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_item   (fq_item),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_item  (qb_item)
  );

  // Hash, probe, assign codes and sequence clear / prefix / end-of-information
  gle_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (qb_valid),
    .q_ready   (qb_ready),
    .q_item    (qb_item),
    .cmd_valid (pk_valid),
    .cmd_ready (pk_ready),
    .cmd       (pk_cmd),
    .wiping    (wiping)
  );

  // Pack codes LSB first and drive the output transaction
  gle_packer u_packer (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (pk_valid),
    .cmd_ready     (pk_ready),
    .cmd           (pk_cmd),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// File: src/gle_front.sv
// Input side: configuration register, frame tracking and pixel classification.
module gle_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [3:0]     cfg_data,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  input  logic [7:0]     s_axis_tdata,   // [7:0] pixel_index
  input  logic           s_axis_tlast,   // last_pixel
  input  logic           wiping,
  output logic           q_valid,
  input  logic           q_ready,
  output gle_pkg::item_t q_item
);
  import gle_pkg::*;

  logic [3:0] min_code_size;
  logic [3:0] frame_min;
  logic       frame_open;
  logic [3:0] clamped;
  logic [3:0] fm_use;
  logic       accept;

  always_comb begin
    priority if (min_code_size < MIN_SIZE_LO) begin
      clamped = MIN_SIZE_LO;
    end else if (min_code_size > MIN_SIZE_HI) begin
      clamped = MIN_SIZE_HI;
    end else begin
      clamped = min_code_size;
    end
  end

  assign fm_use        = frame_open ? frame_min : clamped;
  assign cfg_ready     = 1'b1;
  assign s_axis_tready = q_ready && !wiping;
  assign q_valid       = s_axis_tvalid && !wiping;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    q_item.start = !frame_open;
    q_item.last  = s_axis_tlast;
    q_item.fm    = fm_use;
    q_item.pix   = s_axis_tdata & ((8'd1 << fm_use) - 8'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_code_size <= MIN_SIZE_RST;
      frame_min     <= MIN_SIZE_RST;
      frame_open    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        min_code_size <= cfg_data;
      end
      if (accept) begin
        frame_open <= !s_axis_tlast;
        frame_min  <= fm_use;
      end
    end
  end

endmodule

// File: src/gle_queue.sv
// Short FIFO of classified pixels between front and back.
module gle_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  gle_pkg::item_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output gle_pkg::item_t out_item
);
  import gle_pkg::*;

  item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign in_ready  = count < QCNT_W'(QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign out_item  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: src/gle_back.sv
// Dictionary engine: hash, linear probe, code assignment and code sequencing.
module gle_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_ready,
  input  gle_pkg::item_t    q_item,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output gle_pkg::pk_cmd_t  cmd,
  output logic              wiping
);
  import gle_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_HASH     = 4'd1;
  localparam logic [3:0] S_PROBE    = 4'd2;
  localparam logic [3:0] S_CMP      = 4'd3;
  localparam logic [3:0] S_EMIT_P   = 4'd4;
  localparam logic [3:0] S_EMIT_RST = 4'd5;
  localparam logic [3:0] S_EMIT_CLR = 4'd6;
  localparam logic [3:0] S_FIN_P    = 4'd7;
  localparam logic [3:0] S_FIN_E    = 4'd8;
  localparam logic [3:0] S_WIPE     = 4'd9;

  dict_entry_t mem [TABLE_SIZE];
  dict_entry_t rd_data;

  logic [3:0]         state;
  logic [CODE_W-1:0]  prefix;
  logic [7:0]         pix;
  logic               last_f;
  logic [3:0]         fm;
  logic [3:0]         width;
  logic [CODE_W-1:0]  lac;
  logic [KEY_W-1:0]   key;
  logic [HASH_W-1:0]  hraw;
  logic [IDX_W-1:0]   addr;
  logic [EPOCH_W-1:0] epoch;
  logic               wipe_pending;
  logic [IDX_W-1:0]   wipe_addr;

  logic [CODE_W-1:0]  clear_code;
  logic [CODE_W-1:0]  lac_inc;
  logic [CODE_W:0]    width_lim;
  logic               bump_ins;
  logic               bump_fin;
  logic [31:0]        prod;
  logic [IDX_W-1:0]   addr_inc;
  logic [IDX_W-1:0]   rd_addr;
  logic               cmd_fire;
  logic               entry_live;
  logic               key_hit;
  logic               epoch_wrap;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_wa;
  dict_entry_t        mem_wd;

  assign clear_code = CODE_W'(1) << fm;
  assign lac_inc    = lac + 1'b1;
  assign width_lim  = (CODE_W+1)'(1) << width;
  assign bump_ins   = ({1'b0, lac_inc} >= width_lim) && (width < MAX_WIDTH);
  assign bump_fin   = (({1'b0, lac} + 1'b1) >= width_lim) && (width < MAX_WIDTH);
  assign prod       = 32'(key) * HASH_MUL;
  assign addr_inc   = (addr == IDX_W'(TABLE_SIZE - 1)) ? '0 : addr + 1'b1;
  assign rd_addr    = (state == S_PROBE) ? reduce_hash(hraw) : addr_inc;
  assign cmd_fire   = cmd_valid && cmd_ready;
  assign entry_live = rd_data.epoch == epoch;
  assign key_hit    = rd_data.key == key;
  assign epoch_wrap = epoch == '1;
  assign wiping     = state == S_WIPE;
  assign q_ready    = (state == S_IDLE) && !wipe_pending;

  // Code requests to the packer
  always_comb begin
    cmd_valid       = 1'b0;
    cmd.final_code  = 1'b0;
    cmd.width       = width;
    cmd.code        = prefix;
    unique case (state)
      S_EMIT_P, S_FIN_P: begin
        cmd_valid = 1'b1;
      end
      S_EMIT_RST, S_EMIT_CLR: begin
        cmd_valid = 1'b1;
        cmd.code  = clear_code;
      end
      S_FIN_E: begin
        cmd_valid      = 1'b1;
        cmd.code       = clear_code + 1'b1;
        cmd.final_code = 1'b1;
      end
      default: begin
        cmd_valid = 1'b0;
      end
    endcase
  end

  // Dictionary memory: one write port, one registered read port
  assign mem_we = (state == S_WIPE) || ((state == S_EMIT_P) && cmd_fire);
  assign mem_wa = (state == S_WIPE) ? wipe_addr : addr;
  always_comb begin
    if (state == S_WIPE) begin
      mem_wd = '0;
    end else begin
      mem_wd.epoch = epoch;
      mem_wd.key   = key;
      mem_wd.code  = lac_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_WIPE;
      wipe_addr    <= '0;
      wipe_pending <= 1'b0;
      epoch        <= EPOCH_W'(1);
      fm           <= MIN_SIZE_RST;
      width        <= MIN_SIZE_RST + 4'd1;
      lac          <= (CODE_W'(1) << MIN_SIZE_RST) + 1'b1;
      prefix       <= '0;
    end else begin
      unique case (state)
        S_WIPE: begin
          if (wipe_addr == IDX_W'(TABLE_SIZE - 1)) begin
            wipe_addr    <= '0;
            wipe_pending <= 1'b0;
            state        <= S_IDLE;
          end else begin
            wipe_addr <= wipe_addr + 1'b1;
          end
        end
        S_IDLE: begin
          priority if (wipe_pending) begin
            state <= S_WIPE;
          end else if (q_valid) begin
            pix    <= q_item.pix;
            last_f <= q_item.last;
            if (q_item.start) begin
              fm    <= q_item.fm;
              width <= q_item.fm + 4'd1;
              lac   <= (CODE_W'(1) << q_item.fm) + 1'b1;
              if (epoch_wrap) begin
                epoch        <= EPOCH_W'(1);
                wipe_pending <= 1'b1;
              end else begin
                epoch <= epoch + 1'b1;
              end
              state <= S_EMIT_CLR;
            end else begin
              key   <= {prefix, q_item.pix};
              state <= S_HASH;
            end
          end
        end
        S_HASH: begin
          hraw  <= prod[31:HASH_SHIFT];
          state <= S_PROBE;
        end
        S_PROBE: begin
          addr  <= reduce_hash(hraw);
          state <= S_CMP;
        end
        S_CMP: begin
          priority if (!entry_live) begin
            state <= S_EMIT_P;
          end else if (key_hit) begin
            prefix <= rd_data.code;
            state  <= last_f ? S_FIN_P : S_IDLE;
          end else begin
            addr <= addr_inc;
          end
        end
        S_EMIT_P: begin
          if (cmd_fire) begin
            lac <= lac_inc;
            if (bump_ins) begin
              width <= width + 4'd1;
            end
            if (lac_inc == MAX_CODE) begin
              state <= S_EMIT_RST;
            end else begin
              prefix <= CODE_W'(pix);
              state  <= last_f ? S_FIN_P : S_IDLE;
            end
          end
        end
        S_EMIT_RST: begin
          if (cmd_fire) begin
            width  <= fm + 4'd1;
            lac    <= clear_code + 1'b1;
            prefix <= CODE_W'(pix);
            if (epoch_wrap) begin
              epoch        <= EPOCH_W'(1);
              wipe_pending <= 1'b1;
            end else begin
              epoch <= epoch + 1'b1;
            end
            state <= last_f ? S_FIN_P : S_IDLE;
          end
        end
        S_EMIT_CLR: begin
          if (cmd_fire) begin
            prefix <= CODE_W'(pix);
            state  <= last_f ? S_FIN_P : S_IDLE;
          end
        end
        S_FIN_P: begin
          if (cmd_fire) begin
            if (bump_fin) begin
              width <= width + 4'd1;
            end
            state <= S_FIN_E;
          end
        end
        S_FIN_E: begin
          if (cmd_fire) begin
            prefix <= '0;
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_width_range: assert property (@(posedge clk) disable iff (rst)
    (width > fm) && (width <= MAX_WIDTH))
    else $error("code width out of range for frame code size");

  a_table_reset: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT_RST && cmd_ready) |=>
      (lac == clear_code + 1'b1) && (width == fm + 4'd1))
    else $error("dictionary reset did not restore width and next code");

  a_probe_addr: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> (addr <= IDX_W'(TABLE_SIZE - 1)))
    else $error("probe address beyond table");

endmodule

// File: src/gle_packer.sv
// Bit packer: variable-width codes in, bytes out LSB first, registered output.
module gle_packer (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  gle_pkg::pk_cmd_t cmd,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,
  output logic             m_axis_tlast
);
  import gle_pkg::*;

  logic [ACC_W-1:0] acc;
  logic [CNT_W-1:0] cnt;
  logic             fin;
  logic             byte_avail;
  logic             byte_last;
  logic             load;

  assign cmd_ready  = (cnt < CNT_W'(8)) && !fin;
  assign byte_avail = (cnt >= CNT_W'(8)) || (fin && cnt != '0);
  assign byte_last  = fin && (cnt <= CNT_W'(8));
  assign load       = byte_avail && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (load) begin
      m_axis_tdata <= acc[7:0];
      m_axis_tlast <= byte_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc           <= '0;
      cnt           <= '0;
      fin           <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cmd_valid && cmd_ready) begin
        acc <= acc | (ACC_W'(cmd.code) << cnt);
        cnt <= cnt + CNT_W'(cmd.width);
        fin <= cmd.final_code;
      end else if (load) begin
        if (byte_last) begin
          acc <= '0;
          cnt <= '0;
          fin <= 1'b0;
        end else begin
          acc <= acc >> 8;
          cnt <= cnt - CNT_W'(8);
        end
      end
      if (load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt < CNT_W'(ACC_W))
    else $error("bit count overflows accumulator");

  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    (load && byte_last) |=> (cnt == '0) && !fin && (acc == '0))
    else $error("packer not empty after final byte");

endmodule
